// ===== src/ppmr_pkg.sv =====
`timescale 1ns / 1ps

package ppmr_pkg;

	// Largest image side and the widths that follow from it.
	localparam int MAX_SIDE = 64;
	localparam int CW = $clog2(MAX_SIDE);
	localparam int SIDE_W = CW + 1;
	localparam int BANK_AW = 2 * CW - 1;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int PIX_W = 24;
	localparam int SIDE_REG_W = 7;

	// Configuration port.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		FMT_4BPP  = 2'd0,
		FMT_8BPP  = 2'd1,
		FMT_16BPP = 2'd2,
		FMT_24BPP = 2'd3
	} fmt_t;

	typedef enum logic {
		XF_MIRROR = 1'b0,
		XF_ROTATE = 1'b1
	} xform_t;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_REQUEST = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		REG_FORMAT    = 2'd0,
		REG_TRANSFORM = 2'd1,
		REG_SIDE      = 2'd2
	} reg_idx_t;

	// Position of a byte stream within the image.
	typedef struct packed {
		logic [CW-1:0] row;
		logic [CW-1:0] col;
		logic [1:0]    phase;
		logic          pix_end;
		logic          img_end;
	} cursor_t;

	// Side in use: clamped to the legal range, rounded down to even for 4 bpp.
	function automatic logic [SIDE_W-1:0] used_side(input logic [SIDE_REG_W-1:0] side_len,
			input fmt_t fmt);
		logic [SIDE_W-1:0] s;
		if (32'(side_len) < 32'd2) begin
			s = SIDE_W'(2);
		end else if (32'(side_len) > 32'(MAX_SIDE)) begin
			s = SIDE_W'(MAX_SIDE);
		end else begin
			s = SIDE_W'(side_len);
		end
		if (fmt == FMT_4BPP) begin
			s[0] = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== src/ppmr_in_if.sv =====
`timescale 1ns / 1ps

interface ppmr_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// ===== src/ppmr_out_if.sv =====
`timescale 1ns / 1ps

interface ppmr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/ppmr_store.sv =====
`timescale 1ns / 1ps

// Frame store in two banks. A pixel at row r, column c lives in bank (r ^ c) & 1
// at address {r, c >> 1}, so two horizontally or vertically adjacent pixels
// always sit in different banks and can be accessed in the same cycle.
module ppmr_store (
	input  logic                                  clk,
	input  logic [1:0]                            we,
	input  logic [1:0][ppmr_pkg::BANK_AW-1:0]     waddr,
	input  logic [1:0][ppmr_pkg::PIX_W-1:0]       wdata,
	input  logic                                  re,
	input  logic [1:0][ppmr_pkg::BANK_AW-1:0]     raddr,
	output logic [1:0][ppmr_pkg::PIX_W-1:0]       rdata
);
	import ppmr_pkg::*;

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic [PIX_W-1:0] mem [BANK_DEPTH];

		// One write port and one registered read port per bank.
		always_ff @(posedge clk) begin
			if (we[b]) begin
				mem[waddr[b]] <= wdata[b];
			end
			if (re) begin
				rdata[b] <= mem[raddr[b]];
			end
		end
	end

endmodule

// ===== src/ppmr_cursor.sv =====
`timescale 1ns / 1ps

// Row, column and byte phase of one byte stream, wrapping at the image end.
module ppmr_cursor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic                          advance,
	input  ppmr_pkg::fmt_t                fmt,
	input  logic [ppmr_pkg::SIDE_W-1:0]   side,
	output ppmr_pkg::cursor_t             pos
);
	import ppmr_pkg::*;

	logic [CW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [1:0]        phase_q;
	logic [1:0]        phase_max;
	logic [SIDE_W-1:0] col_step;
	logic              col_last;
	logic              row_last;
	logic              pix_end;

	// Bytes per pixel less one, and pixels per byte as a column step.
	always_comb begin
		unique case (fmt)
			FMT_4BPP:  phase_max = 2'd0;
			FMT_8BPP:  phase_max = 2'd0;
			FMT_16BPP: phase_max = 2'd1;
			FMT_24BPP: phase_max = 2'd2;
		endcase
		col_step = (fmt == FMT_4BPP) ? SIDE_W'(2) : SIDE_W'(1);
	end

	assign pix_end  = (phase_q == phase_max);
	assign col_last = ({1'b0, col_q} == side - col_step);
	assign row_last = ({1'b0, row_q} == side - SIDE_W'(1));

	assign pos.row     = row_q;
	assign pos.col     = col_q;
	assign pos.phase   = phase_q;
	assign pos.pix_end = pix_end;
	assign pos.img_end = pix_end && col_last && row_last;

	// Step one byte; move to the next pixel once the current one is complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			phase_q <= '0;
		end else if (restart) begin
			row_q   <= '0;
			col_q   <= '0;
			phase_q <= '0;
		end else if (advance) begin
			if (!pix_end) begin
				phase_q <= phase_q + 2'd1;
			end else begin
				phase_q <= '0;
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(col_step);
				end
			end
		end
	end

endmodule

// ===== src/packed_pixel_mirror_rotate.sv =====
`timescale 1ns / 1ps

// A request item's byte passes the request stage and then the output register;
// the frame store's registered read port sets this two-stage request path.
// Throughput: one item per cycle, loads and requests in any mix, if not stalled.
// Reset: clears stream positions and handshake state and sets the registers to
// 8 bpp, mirror, side 64; the frame store is not cleared.
module packed_pixel_mirror_rotate (
	input  logic                          clk,
	input  logic                          arst_n,
	ppmr_in_if.sink                       pix_in,
	ppmr_out_if.source                    pix_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppmr_pkg::APB_AW-1:0]   paddr,
	input  logic [ppmr_pkg::APB_DW-1:0]   pwdata,
	output logic [ppmr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import ppmr_pkg::*;

	// Configuration registers.
	fmt_t                  fmt_q;
	xform_t                xform_q;
	logic [SIDE_REG_W-1:0] side_len_q;
	logic                  cfg_we;
	logic                  restart;
	logic [SIDE_W-1:0]     side;
	logic [SIDE_W-1:0]     side_m1;

	// Streams and handshakes.
	cursor_t               lpos;
	cursor_t               rpos;
	logic                  in_acc;
	logic                  load_acc;
	logic                  req_acc;
	logic                  adv;
	logic [15:0]           partial_q;
	logic [PIX_W-1:0]      cur_pix_q;

	// Frame store ports.
	logic [1:0]                  st_we;
	logic [1:0][BANK_AW-1:0]     st_waddr;
	logic [1:0][PIX_W-1:0]       st_wdata;
	logic [1:0][BANK_AW-1:0]     st_raddr;
	logic [1:0][PIX_W-1:0]       st_rdata;
	logic                        wr_bank;
	logic                        wr_a;
	logic                        wr_b;
	logic [BANK_AW-1:0]          wr_addr;
	logic [PIX_W-1:0]            wd_a;
	logic [PIX_W-1:0]            wd_b;

	// Read address generation.
	logic [CW-1:0]         mcol_a;
	logic [CW-1:0]         mcol_b;
	logic [CW-1:0]         src_row_a;
	logic [CW-1:0]         src_col_a;
	logic [CW-1:0]         src_row_b;
	logic [CW-1:0]         src_col_b;
	logic                  rd_bank;
	logic [BANK_AW-1:0]    rd_addr_a;
	logic [BANK_AW-1:0]    rd_addr_b;

	// Request stage and output register.
	logic                  valid_s1;
	logic                  bank_s1;
	logic [1:0]            phase_s1;
	logic                  last_s1;
	logic [PIX_W-1:0]      pix_a;
	logic [PIX_W-1:0]      pix_b;
	logic [7:0]            byte_s1;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	// Register writes; any write to a defined register restarts both streams.
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign restart = cfg_we && (paddr[3:2] == REG_FORMAT || paddr[3:2] == REG_TRANSFORM
		|| paddr[3:2] == REG_SIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_8BPP;
			xform_q    <= XF_MIRROR;
			side_len_q <= SIDE_REG_W'(MAX_SIDE);
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_FORMAT:    fmt_q      <= fmt_t'(pwdata[1:0]);
				REG_TRANSFORM: xform_q    <= xform_t'(pwdata[0]);
				REG_SIDE:      side_len_q <= pwdata[SIDE_REG_W-1:0];
				default:       ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_FORMAT:    prdata = APB_DW'(fmt_q);
			REG_TRANSFORM: prdata = APB_DW'(xform_q);
			REG_SIDE:      prdata = APB_DW'(side_len_q);
			default:       prdata = '0;
		endcase
	end

	assign side    = used_side(side_len_q, fmt_q);
	assign side_m1 = side - SIDE_W'(1);

	// The stage ahead of the output register moves whenever that register frees up.
	assign adv          = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || adv;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign load_acc     = in_acc && (pix_in.mode == MODE_LOAD);
	assign req_acc      = in_acc && (pix_in.mode == MODE_REQUEST);

	ppmr_cursor u_load_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.advance (load_acc),
		.fmt     (fmt_q),
		.side    (side),
		.pos     (lpos)
	);

	ppmr_cursor u_read_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.advance (req_acc),
		.fmt     (fmt_q),
		.side    (side),
		.pos     (rpos)
	);

	// Low bytes of a 16 or 24 bpp pixel wait here until its top byte arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
		end else if (restart) begin
			partial_q <= '0;
		end else if (load_acc && !lpos.pix_end) begin
			if (lpos.phase == 2'd0) begin
				partial_q <= {8'h00, pix_in.data_byte};
			end else begin
				partial_q[15:8] <= pix_in.data_byte;
			end
		end
	end

	// Load write data: pixel A at the cursor, pixel B to its right in 4 bpp.
	always_comb begin
		unique case (fmt_q)
			FMT_4BPP:  wd_a = PIX_W'(pix_in.data_byte[7:4]);
			FMT_8BPP:  wd_a = PIX_W'(pix_in.data_byte);
			FMT_16BPP: wd_a = PIX_W'({pix_in.data_byte, partial_q[7:0]});
			FMT_24BPP: wd_a = {pix_in.data_byte, partial_q};
		endcase
		wd_b = PIX_W'(pix_in.data_byte[3:0]);
	end

	assign wr_bank = lpos.row[0] ^ lpos.col[0];
	assign wr_addr = {lpos.row, lpos.col[CW-1:1]};
	assign wr_a    = load_acc && lpos.pix_end;
	assign wr_b    = load_acc && (fmt_q == FMT_4BPP);

	// Steer the two pixels to their banks.
	always_comb begin
		st_waddr[0] = wr_addr;
		st_waddr[1] = wr_addr;
		if (wr_bank) begin
			st_we[1]    = wr_a;
			st_we[0]    = wr_b;
			st_wdata[1] = wd_a;
			st_wdata[0] = wd_b;
		end else begin
			st_we[0]    = wr_a;
			st_we[1]    = wr_b;
			st_wdata[0] = wd_a;
			st_wdata[1] = wd_b;
		end
	end

	// Source pixels of the output position: A at the cursor, B one column right.
	assign mcol_a = CW'(side_m1 - {1'b0, rpos.col});
	assign mcol_b = mcol_a - CW'(1);

	always_comb begin
		unique case (xform_q)
			XF_MIRROR: begin
				src_row_a = rpos.row;
				src_col_a = mcol_a;
				src_row_b = rpos.row;
				src_col_b = mcol_b;
			end
			XF_ROTATE: begin
				src_row_a = mcol_a;
				src_col_a = rpos.row;
				src_row_b = mcol_b;
				src_col_b = rpos.row;
			end
		endcase
	end

	assign rd_bank   = src_row_a[0] ^ src_col_a[0];
	assign rd_addr_a = {src_row_a, src_col_a[CW-1:1]};
	assign rd_addr_b = {src_row_b, src_col_b[CW-1:1]};

	always_comb begin
		if (rd_bank) begin
			st_raddr[1] = rd_addr_a;
			st_raddr[0] = rd_addr_b;
		end else begin
			st_raddr[0] = rd_addr_a;
			st_raddr[1] = rd_addr_b;
		end
	end

	ppmr_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (req_acc),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Request stage: waits for the frame store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			bank_s1  <= rd_bank;
			phase_s1 <= rpos.phase;
			last_s1  <= rpos.img_end;
		end
	end

	assign pix_a = bank_s1 ? st_rdata[1] : st_rdata[0];
	assign pix_b = bank_s1 ? st_rdata[0] : st_rdata[1];

	// Repack: later bytes of a wide pixel come from the held copy.
	always_comb begin
		unique case (fmt_q)
			FMT_4BPP: byte_s1 = {pix_a[3:0], pix_b[3:0]};
			FMT_8BPP: byte_s1 = pix_a[7:0];
			FMT_16BPP, FMT_24BPP: begin
				priority if (phase_s1 == 2'd0) begin
					byte_s1 = pix_a[7:0];
				end else if (phase_s1 == 2'd1) begin
					byte_s1 = cur_pix_q[15:8];
				end else begin
					byte_s1 = cur_pix_q[23:16];
				end
			end
		endcase
	end

	// Held output pixel, captured on the first byte of a wide pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pix_q <= '0;
		end else if (restart) begin
			cur_pix_q <= '0;
		end else if (adv && phase_s1 == 2'd0 && (fmt_q == FMT_16BPP || fmt_q == FMT_24BPP)) begin
			cur_pix_q <= pix_a;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= byte_s1;
			out_last_q <= last_s1;
		end
	end

	assign pix_out.valid    = out_valid_q;
	assign pix_out.out_byte = out_byte_q;
	assign pix_out.last     = out_last_q;

endmodule

// ===== src/ppmr_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the mirror and rotate block.
module ppmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);
	import ppmr_pkg::*;

	// A result that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
		else $error("output payload changed while stalled");

	// The input side only stalls when the output side holds a result back.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// A request's result is on offer once it has passed the request stage and the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode == MODE_REQUEST |=> ##1 out_valid)
		else $error("request item produced no result");

endmodule

bind packed_pixel_mirror_rotate ppmr_checker u_ppmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.in_mode   (pix_in.mode),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_byte  (pix_out.out_byte),
	.out_last  (pix_out.last)
);

// ===== tb/tb_packed_pixel_mirror_rotate.sv =====
`timescale 1ns / 1ps

module tb_packed_pixel_mirror_rotate;
	import ppmr_pkg::*;

	localparam int RANDOM_ITEMS   = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STORE_DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int CORNER_SIDE    = 12;

	typedef enum logic [1:0] {
		STEP_CFG,
		STEP_LOAD,
		STEP_REQ
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		reg_idx_t    ridx;
		logic [31:0] val;
		bit          typed;
		logic [7:0]  exp_byte;
		logic        exp_last;
	} step_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	ppmr_in_if  pix_in_if ();
	ppmr_out_if pix_out_if ();

	packed_pixel_mirror_rotate u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_if),
		.pix_out (pix_out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: frame store, stream positions and registers.
	logic [23:0] frame_px [0:STORE_DEPTH-1];
	logic [13:0] load_at;
	logic [13:0] read_at;
	logic [15:0] partial_px;
	logic [23:0] held_px;
	fmt_t        cfg_fmt;
	xform_t      cfg_xf;
	logic [6:0]  cfg_side;

	out_beat_t awaited_bytes [$];
	step_t     plan [$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;
	bit        out_hold = 1'b0;
	out_beat_t want;

	// Side in use: clamped to 2..MAX_SIDE, made even for 4 bpp.
	function automatic int side_in_use();
		int s;
		s = cfg_side;
		if (s < 2) begin
			s = 2;
		end
		if (s > MAX_SIDE) begin
			s = MAX_SIDE;
		end
		if (cfg_fmt == FMT_4BPP) begin
			s = s & ~1;
		end
		return s;
	endfunction

	function automatic int image_bytes(input int s);
		case (cfg_fmt)
			FMT_4BPP:  return s * s / 2;
			FMT_8BPP:  return s * s;
			FMT_16BPP: return s * s * 2;
			default:   return s * s * 3;
		endcase
	endfunction

	function automatic void put_pixel(input int s, input int pix, input logic [23:0] v);
		frame_px[(pix / s) * MAX_SIDE + pix % s] = v;
	endfunction

	// Source pixel that lands on output pixel q after the transform.
	function automatic logic [23:0] source_pixel(input int s, input int q);
		int row, col, srow, scol;
		row = q / s;
		col = q % s;
		if (cfg_xf == XF_MIRROR) begin
			srow = row;
			scol = s - 1 - col;
		end else begin
			srow = s - 1 - col;
			scol = row;
		end
		return frame_px[srow * MAX_SIDE + scol];
	endfunction

	// Advances the shadow by one item and gives the byte a request returns.
	function automatic void predict_stream_byte(input mode_t m, input logic [7:0] d,
			output bit has_byte, output logic [7:0] ob, output logic ol);
		int s, total, pos, ph;
		logic [23:0] a, b;
		s = side_in_use();
		total = image_bytes(s);
		has_byte = 1'b0;
		ob = '0;
		ol = 1'b0;
		if (m == MODE_LOAD) begin
			pos = load_at;
			if (pos >= total) begin
				pos = 0;
			end
			case (cfg_fmt)
				FMT_4BPP: begin
					put_pixel(s, 2 * pos, {20'h0, d[7:4]});
					put_pixel(s, 2 * pos + 1, {20'h0, d[3:0]});
				end
				FMT_8BPP: begin
					put_pixel(s, pos, {16'h0, d});
				end
				FMT_16BPP: begin
					if (pos % 2 == 0) begin
						partial_px = {8'h00, d};
					end else begin
						put_pixel(s, pos / 2, {8'h00, d, partial_px[7:0]});
					end
				end
				default: begin
					ph = pos % 3;
					if (ph == 0) begin
						partial_px = {8'h00, d};
					end else if (ph == 1) begin
						partial_px = {d, partial_px[7:0]};
					end else begin
						put_pixel(s, pos / 3, {d, partial_px});
					end
				end
			endcase
			pos++;
			load_at = (pos >= total) ? '0 : 14'(pos);
		end else begin
			pos = read_at;
			if (pos >= total) begin
				pos = 0;
			end
			case (cfg_fmt)
				FMT_4BPP: begin
					a = source_pixel(s, 2 * pos);
					b = source_pixel(s, 2 * pos + 1);
					ob = {a[3:0], b[3:0]};
				end
				FMT_8BPP: begin
					a = source_pixel(s, pos);
					ob = a[7:0];
				end
				FMT_16BPP: begin
					if (pos % 2 == 0) begin
						held_px = source_pixel(s, pos / 2);
						ob = held_px[7:0];
					end else begin
						ob = held_px[15:8];
					end
				end
				default: begin
					ph = pos % 3;
					if (ph == 0) begin
						held_px = source_pixel(s, pos / 3);
					end
					a = held_px >> (8 * ph);
					ob = a[7:0];
				end
			endcase
			ol = (pos + 1 >= total);
			has_byte = 1'b1;
			pos++;
			read_at = (pos >= total) ? '0 : 14'(pos);
		end
	endfunction

	// Offers one item after a random gap and records what it should return.
	task automatic send_item(input mode_t m, input logic [7:0] d, input bit typed,
			input logic [7:0] eb, input logic el);
		int gap;
		bit has_byte;
		logic [7:0] ob;
		logic ol;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pix_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_if.valid <= 1'b1;
		pix_in_if.mode <= m;
		pix_in_if.data_byte <= d;
		@(negedge clk);
		while (!pix_in_if.ready) @(negedge clk);
		predict_stream_byte(m, d, has_byte, ob, ol);
		if (has_byte) begin
			awaited_bytes.push_back(typed ? {eb, el} : {ob, ol});
		end
		@(posedge clk);
	endtask

	// Register write while the block is idle; any write restarts both streams.
	task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
		pix_in_if.valid <= 1'b0;
		while (awaited_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		case (idx)
			REG_FORMAT:    cfg_fmt = fmt_t'(v[1:0]);
			REG_TRANSFORM: cfg_xf = xform_t'(v[0]);
			default:       cfg_side = v[6:0];
		endcase
		load_at = '0;
		read_at = '0;
		partial_px = '0;
		held_px = '0;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void cfg_step(input reg_idx_t r, input int v);
		plan.push_back({STEP_CFG, r, 32'(v), 1'b0, 8'h00, 1'b0});
	endfunction

	function automatic void load_step(input int d);
		plan.push_back({STEP_LOAD, REG_FORMAT, 32'(d), 1'b0, 8'h00, 1'b0});
	endfunction

	function automatic void req_step(input bit typed = 1'b0, input int eb = 0,
			input bit el = 1'b0);
		plan.push_back({STEP_REQ, REG_FORMAT, 32'h0, typed, 8'(eb), el});
	endfunction

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : out_side
		int stall;
		pix_out_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (out_hold) begin
				out_hold = 1'b0;
				stall = HOLD_CYCLES;
			end else if (calm) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 4);
			end
			if (stall > 0) begin
				pix_out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_out_if.ready <= 1'b1;
			@(negedge clk);
			while (!pix_out_if.valid) @(negedge clk);
			@(posedge clk);
		end
	end

	// Each result is checked against the oldest expectation.
	always @(negedge clk) begin
		if (arst_n === 1'b1 && pix_out_if.valid && pix_out_if.ready) begin
			if (awaited_bytes.size() == 0) begin
				$display("%0t: result with none expected: out_byte %02h last %0b",
					$time, pix_out_if.out_byte, pix_out_if.last);
				mismatch_count++;
			end else begin
				want = awaited_bytes.pop_front();
				if (pix_out_if.out_byte !== want.data) begin
					$display("%0t: out_byte expected %02h, actual %02h",
						$time, want.data, pix_out_if.out_byte);
					mismatch_count++;
				end
				if (pix_out_if.last !== want.last) begin
					$display("%0t: last expected %0b, actual %0b",
						$time, want.last, pix_out_if.last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: cycles in a row with no item, result or register write.
	always @(negedge clk) begin
		if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int i, s, total, n_load, n_req, random_items, sel;
		bit held;
		logic [6:0] side_val;
		step_t st;
		random_items = 0;
		held = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_in_if.valid <= 1'b0;
		pix_in_if.mode <= MODE_LOAD;
		pix_in_if.data_byte <= '0;
		cfg_fmt = FMT_8BPP;
		cfg_xf = XF_MIRROR;
		cfg_side = 7'd64;
		load_at = '0;
		read_at = '0;
		partial_px = '0;
		held_px = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the top row at the reset setting; the mirrored reads of the
		// directed part only touch that row and the small corner it loads.
		calm = 1'b1;
		for (i = 0; i < MAX_SIDE; i++) begin
			send_item(MODE_LOAD, 8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
		end
		calm = 1'b0;

		// Directed part: reset setting, both transforms on a 2x2 image, 4 bpp,
		// clamped and odd sides, format mismatch, and a write in mid-pixel.
		req_step();
		req_step();
		cfg_step(REG_SIDE, 2);
		load_step(8'h00);
		load_step(8'hFF);
		load_step(8'h12);
		load_step(8'h34);
		req_step(1'b1, 8'hFF, 1'b0);
		req_step(1'b1, 8'h00, 1'b0);
		req_step(1'b1, 8'h34, 1'b0);
		req_step(1'b1, 8'h12, 1'b1);
		cfg_step(REG_TRANSFORM, XF_ROTATE);
		req_step(1'b1, 8'h12, 1'b0);
		req_step(1'b1, 8'h00, 1'b0);
		req_step(1'b1, 8'h34, 1'b0);
		req_step(1'b1, 8'hFF, 1'b1);
		cfg_step(REG_FORMAT, FMT_4BPP);
		load_step(8'hAB);
		load_step(8'hCD);
		req_step(1'b1, 8'hCA, 1'b0);
		req_step(1'b1, 8'hDB, 1'b1);
		cfg_step(REG_TRANSFORM, XF_MIRROR);
		cfg_step(REG_SIDE, 127);
		req_step();
		cfg_step(REG_TRANSFORM, XF_ROTATE);
		cfg_step(REG_SIDE, 1);
		req_step(1'b1, 8'hCA, 1'b0);
		cfg_step(REG_SIDE, 3);
		req_step(1'b1, 8'hCA, 1'b0);
		cfg_step(REG_FORMAT, FMT_16BPP);
		cfg_step(REG_TRANSFORM, XF_MIRROR);
		req_step();
		req_step();
		cfg_step(REG_FORMAT, FMT_24BPP);
		load_step(8'h5A);
		load_step(8'hA5);
		cfg_step(REG_SIDE, 0);
		req_step();
		req_step();
		foreach (plan[k]) begin
			st = plan[k];
			case (st.kind)
				STEP_CFG:  reg_write(st.ridx, st.val);
				STEP_LOAD: send_item(MODE_LOAD, st.val[7:0], 1'b0, '0, 1'b0);
				default:   send_item(MODE_REQUEST, 8'($urandom_range(0, 255)), st.typed,
					st.exp_byte, st.exp_last);
			endcase
		end

		// Fill the top-left corner that every small random image reads back.
		reg_write(REG_FORMAT, FMT_4BPP);
		reg_write(REG_SIDE, CORNER_SIDE);
		calm = 1'b1;
		for (i = 0; i < CORNER_SIDE * CORNER_SIDE / 2; i++) begin
			send_item(MODE_LOAD, 8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
		end
		calm = 1'b0;

		// Random part: mostly whole images loaded and read back, with noise and
		// cut-short loads; large sides only get a short burst of loads.
		while (random_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 1)) begin
				reg_write(REG_FORMAT, $urandom_range(0, 3));
			end
			if ($urandom_range(0, 1)) begin
				reg_write(REG_TRANSFORM, $urandom_range(0, 1));
			end
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				side_val = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1)
					: $urandom_range(65, 127));
			end else if (sel == 1) begin
				side_val = 7'($urandom_range(6, 64));
			end else begin
				side_val = 7'($urandom_range(2, 5));
			end
			reg_write(REG_SIDE, side_val);
			s = side_in_use();
			total = image_bytes(s);
			if (total <= 80) begin
				n_load = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) : total;
				n_req = total + $urandom_range(0, 3);
			end else begin
				n_load = 16;
				n_req = 0;
			end
			// One long stall on the result side while requests keep coming.
			if (!held && random_items >= 150 && total <= 80) begin
				held = 1'b1;
				calm = 1'b0;
				out_hold = 1'b1;
				n_req += 40;
			end
			for (i = 0; i < n_load + n_req; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					send_item((total <= 80) ? mode_t'($urandom_range(0, 1)) : MODE_LOAD,
						8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
					random_items++;
				end
				send_item(i < n_load ? MODE_LOAD : MODE_REQUEST,
					8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
				random_items++;
			end
		end

		// Drain and report.
		pix_in_if.valid <= 1'b0;
		while (awaited_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
